// File: sv/spq_pkg.sv
// Shared types and constants for the stable priority task queue.
package spq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned ID_W          = 16;
    localparam int unsigned PRIO_W        = 8;
    localparam int unsigned OCC_W         = 5;
    localparam int unsigned STATUS_W      = 2;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXECUTE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXECUTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] task_prio;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     out_id;
        logic [PRIO_W-1:0]   out_priority;
        logic [OCC_W-1:0]    occupancy;
    } out_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } slot_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } spq_ctrl_t;

endpackage

// File: sv/spq_cell.sv
// One slot of the sorted chain: keeps, takes the new task, or shifts.
module spq_cell
    import spq_pkg::*;
#(
    parameter int unsigned COUNT_W = 5,
    parameter int unsigned INDEX   = 0
)
(
    input  logic               clk,
    input  spq_ctrl_t          ctrl,
    input  slot_t              new_slot,
    input  logic [COUNT_W-1:0] count,
    input  slot_t              left_slot,
    input  logic               left_keep,
    input  slot_t              right_slot,
    output slot_t              slot,
    output logic               keep
);

    slot_t slot_reg;
    slot_t slot_next;
    logic  occupied;

    assign occupied = count > COUNT_W'(INDEX);
    assign keep     = occupied && (slot_reg.prio >= new_slot.prio);
    assign slot     = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.pop)
        begin
            slot_next = right_slot;
        end
        else if (ctrl.insert && !keep)
        begin
            slot_next = left_keep ? new_slot : left_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// File: sv/stable_priority_task_queue_core.sv
// The result of an item is registered and presented in the cycle after it is accepted.
// Throughput: one item per cycle while in_stall is low; every slot updates in the same
// cycle, so an insert or an execute takes one pass through the cell chain.
// in_stall rises only while a result is held and out_stall is high.
// Reset (rst_n low, asynchronous) empties the queue and clears the result valid flag.
module stable_priority_task_queue_core
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_item,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_item
);

    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_t               out_reg;
    out_t               out_next;

    logic      accept;
    logic      is_insert;
    logic      full;
    logic      empty;
    spq_ctrl_t ctrl;
    slot_t     new_slot;
    slot_t     slots [DEPTH];
    logic      keeps [DEPTH];

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign is_insert = in_item.command == CMD_INSERT;
    assign full      = count_reg == COUNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign ctrl.insert = accept && is_insert && !full;
    assign ctrl.pop    = accept && !is_insert && !empty;
    assign new_slot.id   = in_item.task_id;
    assign new_slot.prio = in_item.task_prio;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        slot_t left_slot;
        slot_t right_slot;
        logic  left_keep;

        if (g == 0)
        begin : g_head
            assign left_slot = new_slot;
            assign left_keep = 1'b1;
        end
        else
        begin : g_body
            assign left_slot = slots[g-1];
            assign left_keep = keeps[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign right_slot = '0;
        end
        else
        begin : g_next
            assign right_slot = slots[g+1];
        end

        spq_cell #(
            .COUNT_W (COUNT_W),
            .INDEX   (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_slot   (new_slot),
            .count      (count_reg),
            .left_slot  (left_slot),
            .left_keep  (left_keep),
            .right_slot (right_slot),
            .slot       (slots[g]),
            .keep       (keeps[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_comb
    begin
        out_next              = out_reg;
        out_next.out_id       = '0;
        out_next.out_priority = '0;
        out_next.occupancy    = OCC_W'(count_next);
        priority if (is_insert && full)
        begin
            out_next.status = ST_FULL;
        end
        else if (is_insert)
        begin
            out_next.status = ST_INSERTED;
        end
        else if (empty)
        begin
            out_next.status = ST_EMPTY;
        end
        else
        begin
            out_next.status       = ST_EXECUTED;
            out_next.out_id       = slots[0].id;
            out_next.out_priority = slots[0].prio;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// File: sv/spq_checker.sv
// Port-level checks for the stable priority task queue, bound to the top level.
module spq_checker
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input out_t out_item
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_EXECUTED
        |-> out_item.out_id == '0 && out_item.out_priority == '0)
        else $error("task fields set on a non-execute result");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_EMPTY |-> out_item.occupancy == '0)
        else $error("empty result with nonzero occupancy");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_FULL |-> out_item.occupancy == FULL_OCC)
        else $error("full result with wrong occupancy");

endmodule

bind stable_priority_task_queue_core spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

// File: bench/stable_priority_task_queue_core_tb.sv
// Testbench for stable_priority_task_queue_core: directed and random items checked against a shadow queue.
`timescale 1ns / 100ps

module stable_priority_task_queue_core_tb;
    import spq_pkg::*;

    localparam int unsigned DEPTH          = DEPTH_DEFAULT;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_item;
    logic out_valid;
    logic out_stall;
    out_t out_item;

    slot_t       shadow_slots[DEPTH];
    int unsigned shadow_count;
    out_t        pending_results[$];
    int unsigned mismatch_count;
    int unsigned hold_cycles;
    bit          idle_enable;

    stable_priority_task_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Applies one item to the shadow queue and returns the result it causes.
    function automatic out_t shadow_step(in_t it);
        out_t        res;
        int unsigned pos;
        int unsigned i;
        res = '0;
        if (it.command == CMD_INSERT)
        begin
            if (shadow_count >= DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < shadow_count && shadow_slots[pos].prio >= it.task_prio)
                    pos++;
                for (i = shadow_count; i > pos; i--)
                    shadow_slots[i] = shadow_slots[i - 1];
                shadow_slots[pos] = '{id: it.task_id, prio: it.task_prio};
                shadow_count++;
                res.status = ST_INSERTED;
            end
        end
        else if (shadow_count == 0)
        begin
            res.status = ST_EMPTY;
        end
        else
        begin
            res.status       = ST_EXECUTED;
            res.out_id       = shadow_slots[0].id;
            res.out_priority = shadow_slots[0].prio;
            for (i = 1; i < shadow_count; i++)
                shadow_slots[i - 1] = shadow_slots[i];
            shadow_count--;
        end
        res.occupancy = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    function automatic in_t make_item(logic cmd, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
        in_t it;
        it.command   = cmd;
        it.task_id   = id;
        it.task_prio = prio;
        return it;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_item(in_t it);
        int unsigned gap;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(shadow_step(it));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall bursts, or one long hold when requested.
    initial
    begin
        int unsigned burst;
        bit          next_stall;
        burst     = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                next_stall = 1'b1;
                hold_cycles--;
            end
            else if (burst != 0)
            begin
                next_stall = 1'b1;
                burst--;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                burst      = $urandom_range(0, 6);
                next_stall = 1'b1;
            end
            else
            begin
                next_stall = 1'b0;
            end
            out_stall <= next_stall;
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %p", out_item));
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.status != want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              out_item.status, want.status));
                if (out_item.out_id != want.out_id)
                    report_mismatch($sformatf("out_id %h, want %h",
                                              out_item.out_id, want.out_id));
                if (out_item.out_priority != want.out_priority)
                    report_mismatch($sformatf("out_priority %h, want %h",
                                              out_item.out_priority, want.out_priority));
                if (out_item.occupancy != want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, want %0d",
                                              out_item.occupancy, want.occupancy));
            end
        end
    end

    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic test_empty_execute();
        send_item(make_item(CMD_EXECUTE, 16'hFFFF, 8'hFF));
        send_item(make_item(CMD_EXECUTE, 16'h0000, 8'h00));
    endtask

    // Extreme ids and priorities, ties kept in arrival order.
    task automatic test_field_extremes();
        send_item(make_item(CMD_INSERT, 16'h0000, 8'h00));
        send_item(make_item(CMD_INSERT, 16'hFFFF, 8'hFF));
        send_item(make_item(CMD_INSERT, 16'h1234, 8'h80));
        send_item(make_item(CMD_INSERT, 16'h5678, 8'h80));
        send_item(make_item(CMD_INSERT, 16'hAAAA, 8'hFF));
        send_item(make_item(CMD_INSERT, 16'h5555, 8'h00));
        send_item(make_item(CMD_EXECUTE, 16'h5A5A, 8'hA5));
        send_item(make_item(CMD_EXECUTE, 16'h0000, 8'h00));
    endtask

    task automatic test_fill_and_reject();
        while (shadow_count < DEPTH)
            send_item(make_item(CMD_INSERT, 16'($urandom), 8'($urandom_range(0, 3))));
        send_item(make_item(CMD_INSERT, 16'hFFFF, 8'hFF));
        send_item(make_item(CMD_EXECUTE, 16'h0000, 8'h00));
        send_item(make_item(CMD_EXECUTE, 16'h0000, 8'h00));
        wait_drained();
    endtask

    // Receiver holds off while items keep coming, so the block stalls its input.
    task automatic test_backpressure();
        idle_enable = 1'b0;
        hold_cycles = 80;
        repeat (40)
            send_item(make_item(logic'($urandom_range(0, 1)), 16'($urandom),
                                8'($urandom_range(0, 255))));
        wait_drained();
    endtask

    task automatic test_random_traffic(int unsigned count, bit with_idle);
        int unsigned n;
        int unsigned insert_weight;
        int unsigned prio_max;
        idle_enable   = with_idle;
        insert_weight = 5;
        prio_max      = 255;
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                insert_weight = $urandom_range(2, 8);
                case ($urandom_range(0, 2))
                    0:       prio_max = 3;
                    1:       prio_max = 15;
                    default: prio_max = 255;
                endcase
            end
            if (n % 200 == 199)
                wait_drained();
            send_item(make_item(($urandom_range(0, 9) < insert_weight) ? CMD_INSERT : CMD_EXECUTE,
                                16'($urandom), 8'($urandom_range(0, prio_max))));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        idle_enable    = 1'b0;
        hold_cycles    = 0;
        mismatch_count = 0;
        shadow_count   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_execute();
        test_field_extremes();
        test_fill_and_reject();
        test_backpressure();
        test_random_traffic(800, 1'b1);
        test_random_traffic(200, 1'b0);

        wait_drained();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
